[rtl/multi_pool_bitmap_allocator_defines.svh]
// Assertion macros shared by the allocator's checker.
// No dependencies; included by files that assert.
`ifndef MULTI_POOL_BITMAP_ALLOCATOR_DEFINES_SVH
`define MULTI_POOL_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MPBA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpba: check failed");

// next-cycle implication, disabled in reset
`define MPBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpba: check failed");

`endif

[rtl/mpba_pkg.sv]
// Shared constants, codes and types for the multi-pool bitmap allocator.
// No dependencies.
package mpba_pkg;

  localparam int NUM_POOLS_DEF     = 4;
  localparam int MAX_INSTANCES_DEF = 64;

  localparam int OPCODE_W    = 2;
  localparam int POOL_W      = 2;
  localparam int INDEX_W     = 6;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 7;
  localparam int ACTIVE_W    = 3;
  localparam int LIMIT_REGS  = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [OPCODE_W-1:0] OP_TAKE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GIVE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_POOLS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_LIMIT_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_LIMIT_1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_LIMIT_2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_LIMIT_3 = 3'd4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

  typedef struct packed {
    logic load;
    logic find;
    logic commit;
  } dp_cmd_t;

endpackage

[rtl/mpba_ctrl.sv]
// Sequencer for the allocator: accept, search, commit, output valid.
// Depends on mpba_pkg.
module mpba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output mpba_pkg::dp_cmd_t cmd
);
  import mpba_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_COMMIT} state_t;

  state_t state;

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    cmd.load      = (state == S_IDLE) && s_axis_tvalid;
    cmd.find      = (state == S_FIND);
    cmd.commit    = (state == S_COMMIT) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) state <= S_FIND;
        end
        S_FIND: state <= S_COMMIT;
        S_COMMIT: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.commit) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

endmodule

[rtl/mpba_datapath.sv]
// Pool bitmaps, held counts, config registers, lowest-free search and result register.
// Depends on mpba_pkg.
module mpba_datapath #(
  parameter int NUM_POOLS     = mpba_pkg::NUM_POOLS_DEF,
  parameter int MAX_INSTANCES = mpba_pkg::MAX_INSTANCES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mpba_pkg::dp_cmd_t                  cmd,
  input  logic                               cfg_we,
  input  logic [mpba_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpba_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [mpba_pkg::OPCODE_W-1:0]      opcode,
  input  logic [mpba_pkg::POOL_W-1:0]        pool,
  input  logic [mpba_pkg::INDEX_W-1:0]       release_index,
  output logic [mpba_pkg::STATUS_W-1:0]      status,
  output logic [mpba_pkg::INDEX_W-1:0]       granted_index,
  output logic                               has_room,
  output logic [mpba_pkg::COUNT_W-1:0]       held_count,
  output logic [mpba_pkg::COUNT_W-1:0]       pool_limit
);
  import mpba_pkg::*;

  localparam int IDX_W  = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int PSEL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;

  logic [ACTIVE_W-1:0]      active_pools;
  logic [COUNT_W-1:0]       pool_limit_reg [LIMIT_REGS];
  logic [MAX_INSTANCES-1:0] occupancy_map [NUM_POOLS];
  logic [COUNT_W-1:0]       held_tally [NUM_POOLS];

  logic [OPCODE_W-1:0] req_opcode;
  logic [POOL_W-1:0]   req_pool;
  logic [INDEX_W-1:0]  req_rel;

  logic                     act_q;
  logic                     found_q;
  logic [IDX_W-1:0]         grant_q;
  logic [MAX_INSTANCES-1:0] mask_q;

  logic [PSEL_W-1:0]        pool_sel;
  logic                     pool_active;
  logic [MAX_INSTANCES-1:0] cur_map;
  logic [COUNT_W-1:0]       cur_tally;
  logic [COUNT_W-1:0]       raw_limit;
  logic [COUNT_W-1:0]       eff_limit;
  logic [MAX_INSTANCES-1:0] mask;
  logic [MAX_INSTANCES-1:0] free_bits;
  logic [IDX_W-1:0]         low_idx;

  logic [MAX_INSTANCES-1:0] map_next;
  logic [COUNT_W-1:0]       tally_next;
  logic [STATUS_W-1:0]      status_next;
  logic [INDEX_W-1:0]       grant_next;
  logic                     upd;
  logic                     rel_ok;

  always_comb begin
    pool_sel    = PSEL_W'(req_pool);
    pool_active = (ACTIVE_W'(req_pool) < active_pools) &&
                  (32'(req_pool) < NUM_POOLS);
    cur_map     = occupancy_map[pool_sel];
    cur_tally   = held_tally[pool_sel];
    raw_limit   = pool_limit_reg[req_pool];
    if (raw_limit == '0 || raw_limit > COUNT_W'(MAX_INSTANCES))
      eff_limit = COUNT_W'(MAX_INSTANCES);
    else
      eff_limit = raw_limit;
    for (int i = 0; i < MAX_INSTANCES; i++) begin
      mask[i] = COUNT_W'(i) < eff_limit;
    end
    free_bits = ~cur_map & mask;
    low_idx   = '0;
    for (int i = MAX_INSTANCES - 1; i >= 0; i--) begin
      if (free_bits[i]) low_idx = IDX_W'(i);
    end
  end

  always_comb begin
    map_next    = cur_map;
    tally_next  = cur_tally;
    status_next = ST_OK;
    grant_next  = '0;
    upd         = 1'b0;
    rel_ok      = (COUNT_W'(req_rel) < COUNT_W'(MAX_INSTANCES)) &&
                  cur_map[req_rel[IDX_W-1:0]];
    if (!act_q) begin
      status_next = ST_INACTIVE;
    end else begin
      unique case (req_opcode)
        OP_TAKE: begin
          if (found_q) begin
            map_next[grant_q] = 1'b1;
            tally_next        = cur_tally + COUNT_W'(1);
            grant_next        = INDEX_W'(grant_q);
            upd               = 1'b1;
          end else begin
            status_next = ST_FULL;
          end
        end
        OP_GIVE: begin
          if (rel_ok) begin
            map_next[req_rel[IDX_W-1:0]] = 1'b0;
            tally_next                   = cur_tally - COUNT_W'(1);
            upd                          = 1'b1;
          end else begin
            status_next = ST_NOT_HELD;
          end
        end
        default: ;  // query, opcode 3 too
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_opcode <= opcode;
      req_pool   <= pool;
      req_rel    <= release_index;
    end
    if (cmd.find) begin
      act_q   <= pool_active;
      found_q <= |free_bits;
      grant_q <= low_idx;
      mask_q  <= mask;
    end
    if (cmd.commit) begin
      status <= status_next;
      if (act_q) begin
        granted_index <= grant_next;
        has_room      <= |(~map_next & mask_q);
        held_count    <= tally_next;
        pool_limit    <= raw_limit;
      end else begin
        granted_index <= '0;
        has_room      <= 1'b0;
        held_count    <= '0;
        pool_limit    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_pools <= ACTIVE_RESET;
      for (int p = 0; p < LIMIT_REGS; p++) pool_limit_reg[p] <= '0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        occupancy_map[p] <= '0;
        held_tally[p]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACTIVE_POOLS: active_pools      <= cfg_data[ACTIVE_W-1:0];
          REG_POOL_LIMIT_0: pool_limit_reg[0] <= cfg_data;
          REG_POOL_LIMIT_1: pool_limit_reg[1] <= cfg_data;
          REG_POOL_LIMIT_2: pool_limit_reg[2] <= cfg_data;
          REG_POOL_LIMIT_3: pool_limit_reg[3] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit && upd) begin
        occupancy_map[pool_sel] <= map_next;
        held_tally[pool_sel]    <= tally_next;
      end
    end
  end

endmodule

[rtl/multi_pool_bitmap_allocator.sv]
// Top level of the multi-pool bitmap allocator: stream ports, config port.
// Depends on mpba_pkg, mpba_ctrl and mpba_datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  s_axis   | s_axis_tvalid/tready    | request item: opcode, pool, release_index
//  m_axis   | m_axis_tvalid/tready    | result item: status .. pool_limit
//  cfg      | cfg_we (always taken)   | cfg_index, cfg_data
//
// Each item goes through three steps: accept, lowest-free search over the pool's bitmap,
// commit of bitmap, count and result register.
// A result held by a stalled m_axis holds the commit; the next item waits.
// Reset clears all bitmaps and counts at once; no clearing pass.
module multi_pool_bitmap_allocator #(
  parameter int NUM_POOLS     = mpba_pkg::NUM_POOLS_DEF,
  parameter int MAX_INSTANCES = mpba_pkg::MAX_INSTANCES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[1:0], pool[3:2], release_index[9:4], zero pad
  input  logic [mpba_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], granted_index[7:2], has_room[8], held_count[15:9],
  // pool_limit[22:16], zero pad
  output logic [mpba_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [mpba_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpba_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mpba_pkg::*;

  dp_cmd_t              cmd;
  logic [STATUS_W-1:0]  status;
  logic [INDEX_W-1:0]   granted_index;
  logic                 has_room;
  logic [COUNT_W-1:0]   held_count;
  logic [COUNT_W-1:0]   pool_limit;

  mpba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  mpba_datapath #(
    .NUM_POOLS     (NUM_POOLS),
    .MAX_INSTANCES (MAX_INSTANCES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (s_axis_tdata[1:0]),
    .pool          (s_axis_tdata[3:2]),
    .release_index (s_axis_tdata[9:4]),
    .status        (status),
    .granted_index (granted_index),
    .has_room      (has_room),
    .held_count    (held_count),
    .pool_limit    (pool_limit)
  );

  assign m_axis_tdata = {1'b0, pool_limit, held_count, has_room, granted_index, status};

endmodule

[rtl/mpba_checker.sv]
// Port-level checks on the allocator, bound to the top level.
// Depends on mpba_pkg and multi_pool_bitmap_allocator_defines.svh.
`include "multi_pool_bitmap_allocator_defines.svh"

module mpba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import mpba_pkg::*;

  logic out_inactive;
  logic out_grant;
  logic out_full;

  assign out_inactive = m_axis_tvalid && (m_axis_tdata[1:0] == ST_INACTIVE);
  assign out_grant    = m_axis_tvalid && (m_axis_tdata[7:2] != '0);
  assign out_full     = m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL);

  `MPBA_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `MPBA_ASSERT_NEXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `MPBA_ASSERT_SAME(a_inactive_zero, clk, rst, out_inactive, m_axis_tdata[23:2] == '0)
  `MPBA_ASSERT_SAME(a_grant_ok, clk, rst, out_grant, m_axis_tdata[1:0] == ST_OK)
  `MPBA_ASSERT_SAME(a_full_no_room, clk, rst, out_full, !m_axis_tdata[8])

endmodule

bind multi_pool_bitmap_allocator mpba_checker u_mpba_checker (.*);
